FILE: design/block_mean_magnitude_log_level_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block mean magnitude level block
// Clocked, reset-gated concurrent assertions that report through $error.
// ----------------------------------------------------------------------------
`ifndef BLOCK_MEAN_MAGNITUDE_LOG_LEVEL_MACROS_SVH
`define BLOCK_MEAN_MAGNITUDE_LOG_LEVEL_MACROS_SVH

// property checked at every rising edge outside reset
`define BMML_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define BMML_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/bmml_pkg.sv
// ----------------------------------------------------------------------------
// bmml_pkg
// Widths, fixed-point constants and an elaboration-time log2 helper.
// ----------------------------------------------------------------------------
`default_nettype none

package bmml_pkg;

	localparam int SAMPLE_W = 12;
	localparam int RAD_W    = 25;   // a*a + b*b
	localparam int ROOT_W   = 21;   // Q13.8 magnitude
	localparam int SUM_W    = 24;   // Q16.8 block sum
	localparam int LOGX_W   = 27;   // sum * 6
	localparam int LOG_W    = 21;   // Q5.16 log2
	localparam int LEVEL_W  = 17;
	localparam int INDEX_W  = 9;

	localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -17'sd43520;
	localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 17'sd9472;
	localparam logic signed [20:0] TWENTY_LN2_Q16 = 21'sd908522;
	localparam int unsigned HALF_RANGE_DENOM = 5733;

	// log2 in Q16 of a positive constant, same steps as the runtime unit
	function automatic logic [LOG_W-1:0] log2_q16_const(input int unsigned x);
		int unsigned n;
		logic [63:0] m;
		logic [15:0] fr;
		n  = 0;
		fr = '0;
		for (int k = 0; k < 31; k++) begin
			if (n < 31 && (x >> (n + 1)) != 0)
				n = n + 1;
		end
		m = 64'(x) << (30 - n);
		for (int i = 0; i < 16; i++) begin
			m  = (m * m) >> 30;
			fr = {fr[14:0], (m >= 64'h8000_0000)};
			if (m >= 64'h8000_0000)
				m = m >> 1;
		end
		return {5'(n), fr};
	endfunction

endpackage

`default_nettype wire

FILE: design/bmml_isqrt.sv
// ----------------------------------------------------------------------------
// bmml_isqrt
// Digit-by-digit integer square root of (rad << 16), one result bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bmml_isqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [bmml_pkg::RAD_W-1:0]  rad,
	output logic                             done,
	output logic [bmml_pkg::ROOT_W-1:0]      root
);
	import bmml_pkg::*;

	localparam int V_W = RAD_W + 17;   // room for root + bit

	logic [V_W-1:0] v_q;
	logic [V_W-1:0] root_q;
	logic [V_W-1:0] bit_q;
	logic [4:0]     cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [V_W-1:0] trial;

	assign trial = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(ROOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= {1'b0, rad, 16'b0};
			root_q <= '0;
			bit_q  <= V_W'(1) << (2 * (ROOT_W - 1));
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q    <= v_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q[ROOT_W-1:0];

endmodule

`default_nettype wire

FILE: design/bmml_log2.sv
// ----------------------------------------------------------------------------
// bmml_log2
// Iterative log2 in Q16: normalize one bit a cycle, then 16 squaring steps
// of the Q30 mantissa on a single multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module bmml_log2 (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [bmml_pkg::LOGX_W-1:0] x,
	output logic                             done,
	output logic [bmml_pkg::LOG_W-1:0]       log2_val
);
	import bmml_pkg::*;

	localparam logic [1:0] L_IDLE = 2'd0;
	localparam logic [1:0] L_NORM = 2'd1;
	localparam logic [1:0] L_SQR  = 2'd2;

	logic [1:0]  state_q;
	logic [3:0]  cnt_q;
	logic        done_q;
	logic [30:0] m_q;
	logic [4:0]  n_q;
	logic [15:0] frac_q;
	logic [61:0] sq;
	logic [31:0] t;

	assign sq = m_q * m_q;
	assign t  = sq[61:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (start)
						state_q <= L_NORM;
				end
				L_NORM: begin
					if (m_q[30]) begin
						state_q <= L_SQR;
						cnt_q   <= '0;
					end
				end
				L_SQR: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= L_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == L_IDLE) begin
			m_q    <= 31'(x);
			n_q    <= 5'd30;
			frac_q <= '0;
		end else if (state_q == L_NORM && !m_q[30]) begin
			m_q <= {m_q[29:0], 1'b0};
			n_q <= n_q - 5'd1;
		end else if (state_q == L_SQR) begin
			frac_q <= {frac_q[14:0], t[31]};
			m_q    <= t[31] ? t[31:1] : t[30:0];
		end
	end

	assign done     = done_q;
	assign log2_val = {n_q, frac_q};

endmodule

`default_nettype wire

FILE: design/block_mean_magnitude_log_level.sv
// Pair beat to ready again: S_RAD, then S_ROOT in the root unit, then S_ACC.
// Closing beat: the log unit runs its normalizing shifts, 16 squarings and a
// hand-off, then S_MUL scales and S_FIN rounds; a zero sum goes straight to
// S_FIN. A level still held in the output register stalls the close.
// One beat in flight at a time; a finished level waits in the output register
// while the next pair is taken. arst_n clears counters, sum and valid at once.
// ----------------------------------------------------------------------------
// block_mean_magnitude_log_level
// Sums sample pair magnitudes over BLOCK_LEN pairs and outputs a signed Q8.8
// 20*ln level of the scaled mean with a wrapping record index.
// ----------------------------------------------------------------------------
`default_nettype none

module block_mean_magnitude_log_level #(
	parameter int BLOCK_LEN    = 5,
	parameter int RECORD_DEPTH = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // sample_a[11:0], sample_b[23:12]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // level_db[16:0], record_index[25:17], 0
);
	import bmml_pkg::*;

	localparam int CNT_W = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
	localparam logic [CNT_W-1:0] IDX_LAST = CNT_W'(RECORD_DEPTH - 1);
	localparam logic [2:0] PAIR_LAST = 3'(BLOCK_LEN - 1);
	localparam logic [LOG_W-1:0] LOG_DEN =
		log2_q16_const(BLOCK_LEN * HALF_RANGE_DENOM);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RAD  = 3'd1;
	localparam logic [2:0] S_ROOT = 3'd2;
	localparam logic [2:0] S_ACC  = 3'd3;
	localparam logic [2:0] S_LOG  = 3'd4;
	localparam logic [2:0] S_MUL  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0]            state_q;
	logic [SAMPLE_W-1:0]   a_q;
	logic [SAMPLE_W-1:0]   b_q;
	logic [2:0]            pair_q;
	logic [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]      idx_q;
	logic                  zero_q;
	logic signed [43:0]    p_q;
	logic                  out_valid_q;
	logic [LEVEL_W-1:0]    level_q;
	logic [INDEX_W-1:0]    out_idx_q;

	logic [23:0]           sq_a;
	logic [23:0]           sq_b;
	logic [RAD_W-1:0]      rad;
	logic                  root_done;
	logic [ROOT_W-1:0]     root;
	logic [SUM_W-1:0]      sum_new;
	logic [LOGX_W-1:0]     sum6;
	logic                  closing;
	logic                  log_start;
	logic                  log_done;
	logic [LOG_W-1:0]      log_val;
	logic signed [22:0]    d;
	logic signed [43:0]    prod;
	logic [43:0]           mag;
	logic [43:0]           mag_rnd;
	logic signed [20:0]    lvl;
	logic signed [LEVEL_W-1:0] lvl_sat;
	logic                  out_free;

	assign sq_a = a_q * a_q;
	assign sq_b = b_q * b_q;
	assign rad  = {1'b0, sq_a} + {1'b0, sq_b};

	bmml_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_RAD),
		.rad    (rad),
		.done   (root_done),
		.root   (root)
	);

	assign sum_new   = sum_q + SUM_W'(root);
	assign sum6      = {1'b0, sum_new, 2'b00} + {2'b00, sum_new, 1'b0};
	assign closing   = (pair_q == PAIR_LAST);
	assign log_start = (state_q == S_ACC) && closing && (sum_new != '0);

	bmml_log2 u_log2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (log_start),
		.x        (sum6),
		.done     (log_done),
		.log2_val (log_val)
	);

	// d = log2(sum*6) - log2(BLOCK_LEN*5733) - 8, Q16
	assign d    = $signed({2'b00, log_val}) - $signed({2'b00, LOG_DEN}) - 23'sd524288;
	assign prod = d * TWENTY_LN2_Q16;

	// round half away from zero on |p| / 2^24, then saturate
	assign mag     = p_q[43] ? 44'(-p_q) : p_q;
	assign mag_rnd = (mag + 44'd8388608) >> 24;
	assign lvl     = p_q[43] ? -$signed({1'b0, mag_rnd[19:0]}) : $signed({1'b0, mag_rnd[19:0]});

	always_comb begin
		if (zero_q || lvl < 21'(LEVEL_MIN))
			lvl_sat = LEVEL_MIN;
		else if (lvl > 21'(LEVEL_MAX))
			lvl_sat = LEVEL_MAX;
		else
			lvl_sat = lvl[LEVEL_W-1:0];
	end

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pair_q      <= '0;
			sum_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid)
						state_q <= S_RAD;
				end
				S_RAD:  state_q <= S_ROOT;
				S_ROOT: begin
					if (root_done)
						state_q <= S_ACC;
				end
				S_ACC: begin
					if (closing) begin
						pair_q  <= '0;
						sum_q   <= '0;
						state_q <= (sum_new == '0) ? S_FIN : S_LOG;
					end else begin
						pair_q  <= pair_q + 3'd1;
						sum_q   <= sum_new;
						state_q <= S_IDLE;
					end
				end
				S_LOG: begin
					if (log_done)
						state_q <= S_MUL;
				end
				S_MUL:  state_q <= S_FIN;
				S_FIN: begin
					if (out_free) begin
						idx_q       <= (idx_q == IDX_LAST) ? '0 : idx_q + CNT_W'(1);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			a_q <= s_axis_tdata[11:0];
			b_q <= s_axis_tdata[23:12];
		end
		if (state_q == S_ACC && closing)
			zero_q <= (sum_new == '0);
		if (state_q == S_MUL)
			p_q <= prod;
		if (state_q == S_FIN && out_free) begin
			level_q   <= lvl_sat;
			out_idx_q <= INDEX_W'(idx_q);
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_idx_q, level_q};

endmodule

`default_nettype wire

FILE: design/bmml_checker.sv
// ----------------------------------------------------------------------------
// bmml_checker
// Port-level checks of the level block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "block_mean_magnitude_log_level_macros.svh"

module bmml_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata
);
	logic in_beat;
	logic out_stall;
	logic signed [16:0] out_level;
	logic level_ok;

	assign in_beat   = s_axis_tvalid && s_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign out_level = m_axis_tdata[16:0];
	assign level_ok  = out_level >= -17'sd43520 && out_level <= 17'sd9472 &&
		m_axis_tdata[31:26] == 6'b0;

	// stalled result beat holds
	`BMML_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "stalled result beat changed")

	// one pair at a time: busy right after a beat
	`BMML_ASSERT_NEXT(a_busy_after_beat, in_beat, !s_axis_tready, "ready right after an input beat")

	// a level never appears the cycle after an input beat
	`BMML_ASSERT(a_no_fast_result, $rose(m_axis_tvalid) |-> !$past(in_beat), "result too soon after input beat")

	// level saturated, padding zero
	`BMML_ASSERT(a_level_range, m_axis_tvalid |-> level_ok, "level out of range")

endmodule

bind block_mean_magnitude_log_level bmml_checker u_bmml_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: block mean magnitude level testbench
// Streams sample pairs into the block with bursty valid and a patterned
// ready on the result side. A behavioral level predictor computes the
// expected level and record index of every closed block. Each result beat
// is checked field by field against the oldest pending level.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bmml_pkg::*;

	localparam int PAIRS_PER_BLOCK = 5;
	localparam int INDEX_WRAP      = 512;
	localparam int RANDOM_PAIRS    = 1425;   // random pairs after the directed table
	localparam logic [31:0] DENOM_HALF_RANGE = 32'd5733;
	localparam longint SCALE_20LN2 = 908522;   // 20*ln(2), Q16

	typedef struct packed {
		logic signed [LEVEL_W-1:0] level;
		logic [INDEX_W-1:0]        index;
	} level_rec_t;

	typedef struct {
		logic [SAMPLE_W-1:0]       a;
		logic [SAMPLE_W-1:0]       b;
		bit                        typed;
		logic signed [LEVEL_W-1:0] level;
		logic [INDEX_W-1:0]        index;
	} pair_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;    // sample_a[11:0], sample_b[23:12]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [31:0] m_axis_tdata;         // level_db[16:0], record_index[25:17], 0

	level_rec_t        pending_levels[$];
	int                errors = 0;

	// predictor state
	int                blk_pairs = 0;
	logic [SUM_W-1:0]  blk_sum = '0;
	logic [INDEX_W-1:0] next_index = '0;

	logic [15:0]       rx_cycle = '0;

	block_mean_magnitude_log_level #(
		.BLOCK_LEN   (PAIRS_PER_BLOCK),
		.RECORD_DEPTH(INDEX_WRAP)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// floor(sqrt((a*a + b*b) * 2^16)), built one result bit at a time
	function automatic logic [ROOT_W-1:0] pair_magnitude(input logic [SAMPLE_W-1:0] a,
			input logic [SAMPLE_W-1:0] b);
		logic [63:0] radicand;
		logic [63:0] trial;
		logic [63:0] root;
		radicand = ((64'(a) * 64'(a)) + (64'(b) * 64'(b))) << 16;
		root = '0;
		for (int i = ROOT_W - 1; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= radicand)
				root = trial;
		end
		return root[ROOT_W-1:0];
	endfunction

	// log2 in Q16: integer part from the top set bit, fraction by squaring
	function automatic longint log2_fixed(input logic [31:0] x);
		int          top;
		logic [63:0] mant;
		logic [15:0] fbits;
		top = 0;
		for (int i = 0; i < 32; i++)
			if (x[i])
				top = i;
		mant = 64'(x) << (30 - top);
		fbits = '0;
		for (int i = 0; i < 16; i++) begin
			mant = (mant * mant) >> 30;
			fbits = {fbits[14:0], mant >= 64'h8000_0000};
			if (mant >= 64'h8000_0000)
				mant = mant >> 1;
		end
		return (longint'(top) << 16) | longint'(fbits);
	endfunction

	function automatic logic signed [LEVEL_W-1:0] block_level(input logic [SUM_W-1:0] sum);
		longint diff;
		longint prod;
		longint mag;
		longint lvl;
		if (sum == '0)
			return LEVEL_MIN;
		diff = log2_fixed(32'(sum) * 32'd6)
			- log2_fixed(32'(PAIRS_PER_BLOCK) * DENOM_HALF_RANGE) - (longint'(8) << 16);
		prod = diff * SCALE_20LN2;
		mag = (prod < 0) ? -prod : prod;
		mag = (mag + (longint'(1) << 23)) >>> 24;
		lvl = (prod < 0) ? -mag : mag;
		if (lvl < longint'(LEVEL_MIN))
			lvl = LEVEL_MIN;
		if (lvl > longint'(LEVEL_MAX))
			lvl = LEVEL_MAX;
		return lvl[LEVEL_W-1:0];
	endfunction

	// advance the block on one accepted pair; returns 1 when the block closes
	function automatic bit accumulate_pair(input logic [SAMPLE_W-1:0] a,
			input logic [SAMPLE_W-1:0] b, output level_rec_t rec);
		blk_sum = blk_sum + SUM_W'(pair_magnitude(a, b));
		blk_pairs++;
		rec = '0;
		if (blk_pairs < PAIRS_PER_BLOCK)
			return 1'b0;
		rec.level = block_level(blk_sum);
		rec.index = next_index;
		next_index = (next_index == INDEX_W'(INDEX_WRAP - 1)) ? '0 : next_index + INDEX_W'(1);
		blk_pairs = 0;
		blk_sum = '0;
		return 1'b1;
	endfunction

	// drive one pair, wait for the beat, then record what it should produce
	task automatic send_pair(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
			input bit typed, input level_rec_t typed_rec);
		level_rec_t rec;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, a};
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (accumulate_pair(a, b, rec))
			pending_levels.push_back(typed ? typed_rec : rec);
	endtask

	task automatic idle_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
	endtask

	task automatic wait_drained();
		while (pending_levels.size() != 0)
			@(posedge clk);
	endtask

	// result side: ready pattern cycles through always-on, coin flip,
	// long periodic stalls and mostly-ready
	always @(negedge clk) begin
		rx_cycle <= rx_cycle + 16'd1;
		case (rx_cycle[9:8])
			2'd0: m_axis_tready <= 1'b1;
			2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
			2'd2: m_axis_tready <= (rx_cycle[4:0] < 5'd6);
			default: m_axis_tready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin : result_check
		level_rec_t want;
		logic signed [LEVEL_W-1:0] got_level;
		logic [INDEX_W-1:0] got_index;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_level = m_axis_tdata[LEVEL_W-1:0];
			got_index = m_axis_tdata[LEVEL_W+INDEX_W-1:LEVEL_W];
			if (pending_levels.size() == 0) begin
				report_mismatch("unexpected level beat, level", got_level, 0);
			end else begin
				want = pending_levels.pop_front();
				if (got_level !== want.level)
					report_mismatch("level_db", got_level, want.level);
				if (got_index !== want.index)
					report_mismatch("record_index", got_index, want.index);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin : stimulus
		pair_row_t  rows[$];
		pair_row_t  row;
		level_rec_t typed_rec;
		logic [SAMPLE_W-1:0] a;
		logic [SAMPLE_W-1:0] b;
		int mode;
		int pos;
		int burst;
		int waited;

		// zero block, max block, smallest nonzero, bit patterns, zero block
		for (int i = 0; i < 25; i++) begin
			row = '{a: '0, b: '0, typed: 1'b0, level: '0, index: '0};
			case (i / 5)
				1: begin
					row.a = 12'hFFF;
					row.b = 12'hFFF;
				end
				2: begin
					row.a = (i == 10) ? 12'd1 : 12'd0;
					row.b = (i == 11) ? 12'd1 : 12'd0;
				end
				3: begin
					case (i % 5)
						0: begin row.a = 12'hAAA; row.b = 12'h555; end
						1: begin row.a = 12'h555; row.b = 12'hAAA; end
						2: begin row.a = 12'hFFF; row.b = 12'h000; end
						3: begin row.a = 12'h000; row.b = 12'hFFF; end
						default: begin row.a = 12'h800; row.b = 12'h001; end
					endcase
				end
				default: ;
			endcase
			// a block of zeros saturates to the floor level
			if (i == 4 || i == 24) begin
				row.typed = 1'b1;
				row.level = LEVEL_MIN;
				row.index = INDEX_W'(i / 5);
			end
			rows.push_back(row);
		end

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		foreach (rows[i]) begin
			typed_rec.level = rows[i].level;
			typed_rec.index = rows[i].index;
			send_pair(rows[i].a, rows[i].b, rows[i].typed, typed_rec);
			if (i % 7 == 3)
				idle_sender($urandom_range(1, 30));
		end
		idle_sender(1);
		wait_drained();

		pos = 0;
		mode = 0;
		burst = $urandom_range(1, 20);
		typed_rec = '0;
		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			if (pos == 0)
				mode = $urandom_range(0, 9);
			case (mode)
				6, 7: begin
					a = $urandom_range(0, 15);
					b = $urandom_range(0, 15);
				end
				8: begin
					a = '0;
					b = '0;
				end
				9: begin
					a = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
					b = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
				end
				default: begin
					a = $urandom_range(0, 4095);
					b = $urandom_range(0, 4095);
				end
			endcase
			send_pair(a, b, 1'b0, typed_rec);
			pos = (pos + 1) % PAIRS_PER_BLOCK;
			if (i == RANDOM_PAIRS / 2) begin
				// hold off mid-block until the level pipe is empty
				idle_sender(1);
				wait_drained();
			end
			burst--;
			if (burst == 0) begin
				if ($urandom_range(0, 3) != 0)
					idle_sender($urandom_range(1, 25));
				burst = $urandom_range(1, 40);
			end
		end
		idle_sender(1);

		waited = 0;
		while (pending_levels.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (80) @(posedge clk);
		if (pending_levels.size() != 0)
			report_mismatch("levels never delivered, count", 0, pending_levels.size());

		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
